@@ src/plst_pkg.sv @@
// shared codes and cell control type for the positional list store
package plst_pkg;

	localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [2:0] MODE_INSERT_AT  = 3'd2;
	localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
	localparam logic [2:0] MODE_POP_BACK   = 3'd4;
	localparam logic [2:0] MODE_REMOVE_AT  = 3'd5;
	localparam logic [2:0] MODE_READ_ALL   = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_INDEX = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [7:0] value;
	} cell_ctl_t;

endpackage

@@ src/plst_cell.sv @@
// one storage cell of the list chain, holds a single byte
module plst_cell import plst_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [IDX_W-1:0] idx,
	input  logic [7:0]       left_data,
	input  logic [7:0]       right_data,
	input  logic [7:0]       head_data,
	output logic [7:0]       data_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [7:0] next_data;

	always_comb begin
		next_data = data_q;
		unique case (ctl.op)
			CELL_INS: begin
				// make room at idx, cells above take their left neighbor
				if (MY_IDX > idx) begin
					next_data = left_data;
				end else if (MY_IDX == idx) begin
					next_data = ctl.value;
				end
			end
			CELL_DEL: begin
				if (MY_IDX >= idx) begin
					next_data = right_data;
				end
			end
			CELL_ROT: begin
				// rotate the occupied part left, idx is the tail
				if (MY_IDX < idx) begin
					next_data = right_data;
				end else if (MY_IDX == idx) begin
					next_data = head_data;
				end
			end
			default: begin
				next_data = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= next_data;
	end

endmodule

@@ src/positional_list_store.sv @@
// positional list store: ordered byte list in a chain of shifting cells
//
//  channel  handshake              payload                  direction
//  req      req_valid/req_ready    mode, position, value    in
//  rsp      rsp_valid/rsp_ready    status, element, last    out
//
// an edit is taken in idle, then checked and applied to the chain in exec
// read all is taken in idle and started in exec, then sends one element per cycle while rsp is free;
// the chain rotates left once per element so cell 0 always holds the next one to send
// a result beat waiting on rsp_ready holds the chain and the state machine
// arst_n clears the element count and control; cell contents are not reset
// a new request is taken while the previous result still waits on rsp_ready
module positional_list_store import plst_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] mode,
	input  logic [4:0] position,
	input  logic [7:0] value,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [1:0] status,
	output logic [7:0] element,
	output logic       last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	state_t        state_q;
	logic [2:0]    mode_q;
	logic [4:0]    position_q;
	logic [7:0]    value_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_cnt_q;
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic [7:0]    element_q;
	logic          last_q;

	logic [PW-1:0] cnt_ext;
	logic [PW-1:0] pos_p;
	logic [PW-1:0] edit_idx;
	logic [PW-1:0] cell_idx;
	logic          is_ins;
	logic          is_del;
	logic          is_read;
	logic [1:0]    status_c;
	logic          out_free;
	logic          last_rd;
	logic          rsp_load;
	cell_ctl_t     ctl;
	logic [7:0]    cell_data [DEPTH];

	assign cnt_ext  = PW'(count_q);
	assign out_free = !rsp_valid_q || rsp_ready;
	assign last_rd  = (PW'(rd_cnt_q) == cnt_ext - PW'(1));

	assign is_ins  = (mode_q == MODE_PUSH_FRONT) || (mode_q == MODE_PUSH_BACK) ||
		(mode_q == MODE_INSERT_AT);
	assign is_del  = (mode_q == MODE_POP_FRONT) || (mode_q == MODE_POP_BACK) ||
		(mode_q == MODE_REMOVE_AT);
	assign is_read = (mode_q == MODE_READ_ALL);

	// a new result beat is loaded this cycle
	assign rsp_load = out_free && (((state_q == S_EXEC) && !(is_read && count_q != '0)) ||
		(state_q == S_READ));

	// 1-based position the operation works on
	always_comb begin
		unique case (mode_q)
			MODE_PUSH_FRONT: pos_p = PW'(1);
			MODE_PUSH_BACK:  pos_p = cnt_ext + PW'(1);
			MODE_INSERT_AT:  pos_p = PW'(position_q);
			MODE_POP_FRONT:  pos_p = PW'(1);
			MODE_POP_BACK:   pos_p = cnt_ext;
			MODE_REMOVE_AT:  pos_p = PW'(position_q);
			default:         pos_p = '0;
		endcase
	end

	assign edit_idx = pos_p - PW'(1);

	always_comb begin
		status_c = ST_OK;
		priority if (is_ins) begin
			if (pos_p == '0 || pos_p > cnt_ext + PW'(1)) begin
				status_c = ST_INDEX;
			end else if (cnt_ext == PW'(DEPTH)) begin
				status_c = ST_FULL;
			end
		end else if (is_del) begin
			if (count_q == '0) begin
				status_c = ST_EMPTY;
			end else if (pos_p == '0 || pos_p > cnt_ext) begin
				status_c = ST_INDEX;
			end
		end else if (is_read) begin
			if (count_q == '0) begin
				status_c = ST_EMPTY;
			end
		end else begin
			status_c = ST_OK;
		end
	end

	always_comb begin
		ctl.op    = CELL_HOLD;
		ctl.value = value_q;
		if (state_q == S_EXEC && out_free && status_c == ST_OK) begin
			if (is_ins) begin
				ctl.op = CELL_INS;
			end else if (is_del) begin
				ctl.op = CELL_DEL;
			end
		end else if (state_q == S_READ && out_free) begin
			ctl.op = CELL_ROT;
		end
	end

	assign cell_idx = (state_q == S_READ) ? cnt_ext - PW'(1) : edit_idx;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [7:0] left_d;
		logic [7:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = 8'd0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign right_d = 8'd0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end
		plst_cell #(
			.INDEX(i),
			.IDX_W(PW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (cell_idx),
			.left_data (left_d),
			.right_data(right_d),
			.head_data (cell_data[0]),
			.data_q    (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= '0;
			position_q  <= '0;
			value_q     <= '0;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			rsp_valid_q <= 1'b0;
			status_q    <= ST_OK;
			element_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						mode_q     <= mode;
						position_q <= position;
						value_q    <= value;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						if (is_read && count_q != '0) begin
							rd_cnt_q <= '0;
							state_q  <= S_READ;
						end else begin
							status_q    <= status_c;
							element_q   <= 8'd0;
							last_q      <= 1'b1;
							if (status_c == ST_OK && is_ins) begin
								count_q <= count_q + CW'(1);
							end else if (status_c == ST_OK && is_del) begin
								count_q <= count_q - CW'(1);
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_READ: begin
					if (out_free) begin
						status_q    <= ST_OK;
						element_q   <= cell_data[0];
						last_q      <= last_rd;
						rd_cnt_q    <= rd_cnt_q + CW'(1);
						if (last_rd) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule
